@@ src/scct_pkg.sv @@
`default_nettype none

package scct_pkg;

    localparam int TIME_FRAC_BITS_DEF = 16;

    // Register stages in front of the time digit stages.
    localparam int FRONT_STAGES = 7;

    localparam int COORD_W  = 32;
    localparam int RAD_W    = 31;
    localparam int DIFF_W   = 33;
    localparam int RSUM_W   = 32;
    localparam int SUM_W    = 66;
    localparam int HALF_W   = 33;
    localparam int WIDE_W   = 132;
    localparam int NUM_W    = 34;
    localparam int NSEL_W   = 35;
    localparam int VEL_W    = 32;
    localparam int OUT_TIME_W = 16;
    localparam int S_TDATA_W  = 320;

    localparam logic [1:0] MODE_CIRCLE = 2'd0;
    localparam logic [1:0] MODE_VWALL  = 2'd1;
    localparam logic [1:0] MODE_HWALL  = 2'd2;

    typedef struct packed {
        logic [1:0]                 mode;
        logic signed [COORD_W-1:0]  self_x;
        logic signed [COORD_W-1:0]  self_y;
        logic signed [COORD_W-1:0]  self_vx;
        logic signed [COORD_W-1:0]  self_vy;
        logic [RAD_W-1:0]           self_radius;
        logic signed [COORD_W-1:0]  other_x;
        logic signed [COORD_W-1:0]  other_y;
        logic signed [COORD_W-1:0]  other_vx;
        logic signed [COORD_W-1:0]  other_vy;
        logic [RAD_W-1:0]           other_radius;
    } item_t;

    typedef struct packed {
        logic             ok;
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] q;
        logic [SUM_W-1:0] c;
    } circ_front_t;

    typedef struct packed {
        logic             ok;
        logic [VEL_W-1:0] n;
        logic [VEL_W-1:0] v;
    } wall_front_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic             c_ok;
        logic [SUM_W-1:0] a;
        logic             w_ok;
        logic [VEL_W-1:0] v;
    } lane_t;

    // Width of the scaled circle residual a*k^2 - 2*q*S*k + c*S^2, signed.
    function automatic int f_width(input int wt);
        return 70 + 2 * wt;
    endfunction

    // Width of q*S - a*k, never negative once a digit is kept.
    function automatic int g_width(input int wt);
        return 67 + wt;
    endfunction

    function automatic logic [DIFF_W-1:0] mag_diff(input logic signed [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] u;
        u = v;
        return v[DIFF_W-1] ? (~u + 1'b1) : u;
    endfunction

endpackage

`default_nettype wire

@@ src/scct_circle_front.sv @@
`default_nettype none

module scct_circle_front
    import scct_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire item_t       item,
    output circ_front_t      res
);

    // Stage 0: relative position and velocity.
    logic signed [DIFF_W-1:0] dx_next, dy_next, dvx_next, dvy_next;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dvx_reg, dvy_reg;
    logic [RSUM_W-1:0]        rsum_reg;
    logic                     vzero0_reg;

    assign dx_next  = DIFF_W'(item.other_x) - DIFF_W'(item.self_x);
    assign dy_next  = DIFF_W'(item.other_y) - DIFF_W'(item.self_y);
    assign dvx_next = DIFF_W'(item.other_vx) - DIFF_W'(item.self_vx);
    assign dvy_next = DIFF_W'(item.other_vy) - DIFF_W'(item.self_vy);

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            dvx_reg    <= dvx_next;
            dvy_reg    <= dvy_next;
            rsum_reg   <= RSUM_W'(item.self_radius) + RSUM_W'(item.other_radius);
            vzero0_reg <= (dvx_next == '0) && (dvy_next == '0);
        end
    end

    // Stage 1: squares and dot product terms on magnitudes.
    logic [DIFF_W-1:0]   mdx, mdy, mdvx, mdvy;
    logic [2*RSUM_W-1:0] rr_prod;
    logic [SUM_W-1:0]    sqvx_reg, sqvy_reg, sqx_reg, sqy_reg, rr1_reg, t1_reg, t2_reg;
    logic                s1_reg, s2_reg, vzero1_reg;

    assign mdx  = mag_diff(dx_reg);
    assign mdy  = mag_diff(dy_reg);
    assign mdvx = mag_diff(dvx_reg);
    assign mdvy = mag_diff(dvy_reg);

    // The full square of the radius sum needs twice the width of the sum.
    assign rr_prod = rsum_reg * rsum_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sqvx_reg   <= mdvx * mdvx;
            sqvy_reg   <= mdvy * mdvy;
            sqx_reg    <= mdx * mdx;
            sqy_reg    <= mdy * mdy;
            rr1_reg    <= SUM_W'(rr_prod);
            t1_reg     <= mdx * mdvx;
            t2_reg     <= mdy * mdvy;
            s1_reg     <= dx_reg[DIFF_W-1] ^ dvx_reg[DIFF_W-1];
            s2_reg     <= dy_reg[DIFF_W-1] ^ dvy_reg[DIFF_W-1];
            vzero1_reg <= vzero0_reg;
        end
    end

    // Stage 2: a = |v|^2, d2 = |d|^2, and the dot product split by sign.
    logic [SUM_W-1:0] a2_reg, d2_reg, rr2_reg, pp_reg, pn_reg;
    logic             vzero2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            a2_reg     <= sqvx_reg + sqvy_reg;
            d2_reg     <= sqx_reg + sqy_reg;
            rr2_reg    <= rr1_reg;
            pp_reg     <= (s1_reg ? '0 : t1_reg) + (s2_reg ? '0 : t2_reg);
            pn_reg     <= (s1_reg ? t1_reg : '0) + (s2_reg ? t2_reg : '0);
            vzero2_reg <= vzero1_reg;
        end
    end

    // Stage 3: c = d2 - R^2 and q = -(d . v).
    logic [SUM_W-1:0] a3_reg, c3_reg, q3_reg;
    logic             pre3_ok_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            a3_reg      <= a2_reg;
            c3_reg      <= d2_reg - rr2_reg;
            q3_reg      <= pn_reg - pp_reg;
            pre3_ok_reg <= !vzero2_reg && (d2_reg >= rr2_reg) && (pp_reg <= pn_reg);
        end
    end

    // Stage 4: partial products of q*q and a*c; also the late-contact test.
    logic [HALF_W-1:0] qh, ql, ah, al, ch, cl;
    logic [SUM_W:0]    ac_sum, q_dbl;
    logic [SUM_W-1:0]  qhh_reg, qhl_reg, qll_reg, ahch_reg, ahcl_reg, alch_reg, alcl_reg;
    logic [SUM_W-1:0]  a4_reg, c4_reg, q4_reg;
    logic              ok4_reg;

    assign qh = q3_reg[SUM_W-1:HALF_W];
    assign ql = q3_reg[HALF_W-1:0];
    assign ah = a3_reg[SUM_W-1:HALF_W];
    assign al = a3_reg[HALF_W-1:0];
    assign ch = c3_reg[SUM_W-1:HALF_W];
    assign cl = c3_reg[HALF_W-1:0];
    assign ac_sum = (SUM_W+1)'(a3_reg) + (SUM_W+1)'(c3_reg);
    assign q_dbl  = {q3_reg, 1'b0};

    always_ff @(posedge aclk) begin
        if (en) begin
            qhh_reg  <= qh * qh;
            qhl_reg  <= qh * ql;
            qll_reg  <= ql * ql;
            ahch_reg <= ah * ch;
            ahcl_reg <= ah * cl;
            alch_reg <= al * ch;
            alcl_reg <= al * cl;
            a4_reg   <= a3_reg;
            c4_reg   <= c3_reg;
            q4_reg   <= q3_reg;
            // The earlier root reaches the end of the step or beyond.
            ok4_reg  <= pre3_ok_reg && !((a3_reg <= q3_reg) && (ac_sum >= q_dbl));
        end
    end

    // Stage 5: assemble q*q and a*c.
    logic [WIDE_W-1:0] qq_reg, acp_reg;
    logic [SUM_W-1:0]  a5_reg, c5_reg, q5_reg;
    logic              ok5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            qq_reg  <= (WIDE_W'(qhh_reg) << (2 * HALF_W)) + (WIDE_W'(qhl_reg) << (HALF_W + 1))
                       + WIDE_W'(qll_reg);
            acp_reg <= (WIDE_W'(ahch_reg) << (2 * HALF_W))
                       + ((WIDE_W'(ahcl_reg) + WIDE_W'(alch_reg)) << HALF_W)
                       + WIDE_W'(alcl_reg);
            a5_reg  <= a4_reg;
            c5_reg  <= c4_reg;
            q5_reg  <= q4_reg;
            ok5_reg <= ok4_reg;
        end
    end

    // Stage 6: the roots are real when q^2 >= a*c.
    always_ff @(posedge aclk) begin
        if (en) begin
            res.ok <= ok5_reg && (qq_reg >= acp_reg);
            res.a  <= a5_reg;
            res.q  <= q5_reg;
            res.c  <= c5_reg;
        end
    end

endmodule

`default_nettype wire

@@ src/scct_wall_front.sv @@
`default_nettype none

module scct_wall_front
    import scct_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   en,
    input  wire item_t  item,
    output wall_front_t res
);

    localparam int DELAY_STAGES = FRONT_STAGES - 4;

    // Stage 0: pick normal and tangential axes, form the gap.
    logic signed [COORD_W-1:0] pn, vn, pt, vt;
    logic signed [NUM_W-1:0]   line_e, r_e, pn_e, num_next;

    always_comb begin
        if (item.mode == MODE_HWALL) begin
            pn = item.self_y;
            vn = item.self_vy;
            pt = item.self_x;
            vt = item.self_vx;
        end else begin
            pn = item.self_x;
            vn = item.self_vx;
            pt = item.self_y;
            vt = item.self_vy;
        end
    end

    assign line_e = NUM_W'(item.other_x);
    assign r_e    = signed'(NUM_W'(item.self_radius));
    assign pn_e   = NUM_W'(pn);
    assign num_next = (pn < item.other_x) ? (line_e - r_e - pn_e) : (line_e + r_e - pn_e);

    logic signed [NUM_W-1:0]   num_reg;
    logic                      vneg_reg, vzero_reg;
    logic [VEL_W-1:0]          v0_reg;
    logic signed [COORD_W-1:0] vt0_reg;
    logic signed [DIFF_W-1:0]  lod0_reg, hid0_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg   <= num_next;
            vneg_reg  <= vn[COORD_W-1];
            vzero_reg <= (vn == '0);
            v0_reg    <= vn[COORD_W-1] ? VEL_W'(-vn) : VEL_W'(vn);
            vt0_reg   <= vt;
            lod0_reg  <= DIFF_W'(item.other_y) - DIFF_W'(pt);
            hid0_reg  <= DIFF_W'(item.other_vx) - DIFF_W'(pt);
        end
    end

    // Stage 1: gap along the direction of motion, check 0 <= n < |v|.
    logic signed [NSEL_W-1:0]  n_sel;
    logic [VEL_W-1:0]          n1_reg, v1_reg;
    logic                      range1_reg;
    logic signed [COORD_W-1:0] vt1_reg;
    logic signed [DIFF_W-1:0]  lod1_reg, hid1_reg;

    assign n_sel = vneg_reg ? -NSEL_W'(num_reg) : NSEL_W'(num_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            n1_reg     <= n_sel[VEL_W-1:0];
            v1_reg     <= v0_reg;
            range1_reg <= !vzero_reg && !n_sel[NSEL_W-1]
                          && ($unsigned(n_sel) < NSEL_W'(v0_reg));
            vt1_reg    <= vt0_reg;
            lod1_reg   <= lod0_reg;
            hid1_reg   <= hid0_reg;
        end
    end

    // Stage 2: tangential position at contact, scaled by |v|.
    logic signed [DIFF_W-1:0]   vs, ns;
    logic signed [2*DIFF_W-1:0] lo_p_reg, mid_p_reg, hi_p_reg;
    logic [VEL_W-1:0]           n2_reg, v2_reg;
    logic                       range2_reg;

    assign vs = signed'({1'b0, v1_reg});
    assign ns = signed'({1'b0, n1_reg});

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_p_reg   <= lod1_reg * vs;
            mid_p_reg  <= DIFF_W'(vt1_reg) * ns;
            hi_p_reg   <= hid1_reg * vs;
            n2_reg     <= n1_reg;
            v2_reg     <= v1_reg;
            range2_reg <= range1_reg;
        end
    end

    // Stage 3: contact point inside the closed span.
    wall_front_t span_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            span_reg.ok <= range2_reg && (lo_p_reg <= mid_p_reg) && (mid_p_reg <= hi_p_reg);
            span_reg.n  <= n2_reg;
            span_reg.v  <= v2_reg;
        end
    end

    // Remaining stages keep step with the circle lane.
    wall_front_t dly_reg [DELAY_STAGES];

    always_ff @(posedge aclk) begin
        if (en) begin
            dly_reg[0] <= span_reg;
            for (int i = 1; i < DELAY_STAGES; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign res = dly_reg[DELAY_STAGES-1];

endmodule

`default_nettype wire

@@ src/scct_digit_stage.sv @@
`default_nettype none

module scct_digit_stage
    import scct_pkg::*;
#(
    parameter int TIME_FRACTION_BITS = TIME_FRAC_BITS_DEF,
    parameter int BIT_POS = 0
) (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire lane_t                             lane_in,
    input  wire logic [f_width(TIME_FRACTION_BITS)-1:0] f_in,
    input  wire logic [g_width(TIME_FRACTION_BITS)-1:0] g_in,
    input  wire logic [TIME_FRACTION_BITS-1:0]     ck_in,
    input  wire logic [VEL_W-1:0]                  rem_in,
    input  wire logic [TIME_FRACTION_BITS-1:0]     wk_in,
    output lane_t                                  lane_out,
    output logic [f_width(TIME_FRACTION_BITS)-1:0] f_out,
    output logic [g_width(TIME_FRACTION_BITS)-1:0] g_out,
    output logic [TIME_FRACTION_BITS-1:0]          ck_out,
    output logic [VEL_W-1:0]                       rem_out,
    output logic [TIME_FRACTION_BITS-1:0]          wk_out
);

    localparam int FW  = f_width(TIME_FRACTION_BITS);
    localparam int GW  = g_width(TIME_FRACTION_BITS);
    localparam int GW1 = GW + 1;

    // Circle: try k + 2^b. With F(k) and G(k) = q*S - a*k,
    // F(k + 2^b) = F(k) - 2^(b+1)*G(k) + a*2^(2b), G(k + 2^b) = G(k) - a*2^b.
    logic [GW1-1:0] g_try;
    logic [FW-1:0]  f_try;
    logic           take;

    assign g_try = {1'b0, g_in} - (GW1'(lane_in.a) << BIT_POS);
    assign f_try = f_in - (FW'(g_in) << (BIT_POS + 1)) + (FW'(lane_in.a) << (2 * BIT_POS));
    assign take  = !g_try[GW1-1] && !f_try[FW-1];

    // Wall: one restoring division step of n*2^T by |v|.
    logic [VEL_W:0] rem2, rem_sub;
    logic           wtake;

    assign rem2    = {rem_in, 1'b0};
    assign rem_sub = rem2 - (VEL_W+1)'(lane_in.v);
    assign wtake   = (rem2 >= (VEL_W+1)'(lane_in.v));

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_out <= lane_in;
            f_out    <= take ? f_try : f_in;
            g_out    <= take ? g_try[GW-1:0] : g_in;
            ck_out   <= take ? (ck_in | (TIME_FRACTION_BITS'(1) << BIT_POS)) : ck_in;
            rem_out  <= wtake ? rem_sub[VEL_W-1:0] : rem2[VEL_W-1:0];
            wk_out   <= wtake ? (wk_in | (TIME_FRACTION_BITS'(1) << BIT_POS)) : wk_in;
        end
    end

endmodule

`default_nettype wire

@@ src/swept_circle_collision_time_top.sv @@
// Swept circle collision time.
// Input channel s_*: one item per query. s_tuser carries the mode (circle against
// circle, vertical wall, horizontal wall); s_tdata carries the Q16.16 geometry.
// Result channel m_*: one item per query. m_tuser is the hit flag and m_tdata
// holds the contact time as an unsigned fraction of the step, zero without a hit.
// Throughput: one item per cycle while the skid register is empty. From the
// accepting edge to m_tvalid an item passes seven stages of products and
// compares, then one stage per bit of the contact time, then the output register.
// The whole pipeline moves on a single enable. Results land in an output register
// backed by one skid register; s_tready drops only while the skid register is
// full, so the block keeps accepting while one finished result waits and stops
// cleanly when the receiver stalls longer, with nothing lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits and the output buffer;
// no configuration or state survives between items.
`default_nettype none

module swept_circle_collision_time_top
    import scct_pkg::*;
#(
    parameter int TIME_FRACTION_BITS = TIME_FRAC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // self_x, self_y, self_vx, self_vy, self_radius, other_x, other_y,
    // other_vx, other_vy, other_radius, zero pad
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // mode
    input  wire logic [1:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // contact_time
    output logic [OUT_TIME_W-1:0]      m_tdata,
    // hit
    output logic                       m_tuser
);

    localparam int FW = f_width(TIME_FRACTION_BITS);
    localparam int GW = g_width(TIME_FRACTION_BITS);
    localparam int PIPE_DEPTH = FRONT_STAGES + TIME_FRACTION_BITS;

    typedef struct packed {
        logic                  hit;
        logic [OUT_TIME_W-1:0] ctime;
    } result_t;

    logic en;
    item_t item;

    always_comb begin
        item.mode         = s_tuser;
        item.self_x       = s_tdata[31:0];
        item.self_y       = s_tdata[63:32];
        item.self_vx      = s_tdata[95:64];
        item.self_vy      = s_tdata[127:96];
        item.self_radius  = s_tdata[158:128];
        item.other_x      = s_tdata[190:159];
        item.other_y      = s_tdata[222:191];
        item.other_vx     = s_tdata[254:223];
        item.other_vy     = s_tdata[286:255];
        item.other_radius = s_tdata[317:287];
    end

    // Valid bits and mode travel alongside the data.
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [1:0]            mode_reg [FRONT_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode_reg[0] <= s_tuser;
            for (int i = 1; i < FRONT_STAGES; i++) begin
                mode_reg[i] <= mode_reg[i-1];
            end
        end
    end

    circ_front_t cf;
    wall_front_t wf;

    scct_circle_front u_circle (
        .aclk (aclk),
        .en   (en),
        .item (item),
        .res  (cf)
    );

    scct_wall_front u_wall (
        .aclk (aclk),
        .en   (en),
        .item (item),
        .res  (wf)
    );

    lane_t                         lane_chain [TIME_FRACTION_BITS+1];
    logic [FW-1:0]                 f_chain    [TIME_FRACTION_BITS+1];
    logic [GW-1:0]                 g_chain    [TIME_FRACTION_BITS+1];
    logic [TIME_FRACTION_BITS-1:0] ck_chain   [TIME_FRACTION_BITS+1];
    logic [VEL_W-1:0]              rem_chain  [TIME_FRACTION_BITS+1];
    logic [TIME_FRACTION_BITS-1:0] wk_chain   [TIME_FRACTION_BITS+1];

    always_comb begin
        lane_chain[0].mode = mode_reg[FRONT_STAGES-1];
        lane_chain[0].c_ok = cf.ok;
        lane_chain[0].a    = cf.a;
        lane_chain[0].w_ok = wf.ok;
        lane_chain[0].v    = wf.v;
    end

    // At k = 0 the residual is c*S^2 and the vertex bound is q*S.
    assign f_chain[0]   = FW'(cf.c) << (2 * TIME_FRACTION_BITS);
    assign g_chain[0]   = GW'(cf.q) << TIME_FRACTION_BITS;
    assign ck_chain[0]  = '0;
    assign rem_chain[0] = wf.n;
    assign wk_chain[0]  = '0;

    for (genvar j = 0; j < TIME_FRACTION_BITS; j++) begin : g_digit
        scct_digit_stage #(
            .TIME_FRACTION_BITS (TIME_FRACTION_BITS),
            .BIT_POS            (TIME_FRACTION_BITS - 1 - j)
        ) u_digit (
            .aclk     (aclk),
            .en       (en),
            .lane_in  (lane_chain[j]),
            .f_in     (f_chain[j]),
            .g_in     (g_chain[j]),
            .ck_in    (ck_chain[j]),
            .rem_in   (rem_chain[j]),
            .wk_in    (wk_chain[j]),
            .lane_out (lane_chain[j+1]),
            .f_out    (f_chain[j+1]),
            .g_out    (g_chain[j+1]),
            .ck_out   (ck_chain[j+1]),
            .rem_out  (rem_chain[j+1]),
            .wk_out   (wk_chain[j+1])
        );
    end

    // Pick the lane that matches the mode.
    result_t res;
    lane_t   lane_last;
    logic    sel_hit;
    logic [TIME_FRACTION_BITS-1:0] sel_k;

    assign lane_last = lane_chain[TIME_FRACTION_BITS];

    always_comb begin
        unique case (lane_last.mode)
            MODE_CIRCLE: begin
                sel_hit = lane_last.c_ok;
                sel_k   = ck_chain[TIME_FRACTION_BITS];
            end
            MODE_VWALL, MODE_HWALL: begin
                sel_hit = lane_last.w_ok;
                sel_k   = wk_chain[TIME_FRACTION_BITS];
            end
            default: begin
                sel_hit = 1'b0;
                sel_k   = '0;
            end
        endcase
        res.hit   = sel_hit;
        res.ctime = sel_hit ? OUT_TIME_W'(sel_k) : '0;
    end

    // Output register with one skid register behind it.
    result_t out_reg, out_next, skid_reg, skid_next;
    logic    out_valid_reg, out_valid_next, skid_valid_reg, skid_valid_next;
    logic    push, pop;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign push     = en && valid_reg[PIPE_DEPTH-1];
    assign pop      = out_valid_reg && m_tready;

    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = res;
                out_valid_next = push;
            end
        end else if (push) begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.ctime;
    assign m_tuser  = out_reg.hit;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds an item while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid register filled without a stalled output");

    a_skid_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !m_tready |=> skid_valid_reg)
        else $error("waiting item left the skid register during a stall");

    a_miss_zero_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("contact time nonzero on a miss");

endmodule

`default_nettype wire
